// ----- design/lspa_pkg.sv -----
// ----------------------------------------------------------------------------
// Slot pool allocator package
// Beat types for the request and result channels, request codes and the
// fixed field widths shared by the allocator modules.
// ----------------------------------------------------------------------------
package lspa_pkg;

  // Fixed field widths of the channel beats.
  localparam int unsigned LIFE_IN_W  = 24;
  localparam int unsigned ELAPSED_W  = 16;
  localparam int unsigned SLOT_OUT_W = 8;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned CFG_W      = 9;

  // Request codes carried in req_type.
  localparam logic REQ_SPAWN = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // Request beat.
  typedef struct packed {
    logic                 req_type;
    logic [LIFE_IN_W-1:0] lifetime;
    logic [ELAPSED_W-1:0] elapsed;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot_index;
    logic                  evicted;
    logic [COUNT_W-1:0]    alive_count;
  } out_beat_t;

endpackage

// ----- design/lifetime_slot_pool_allocator_core.sv -----
// ----------------------------------------------------------------------------
// Lifetime slot pool allocator
// Allocates slots from a pool with a round-robin search for a dead slot and
// eviction when the active part of the pool is full; ticks age every slot.
//
//   channel  direction  handshake        beat
//   in_      input      valid / stall    in_beat_t  (spawn or tick request)
//   out_     output     valid / stall    out_beat_t (slot, eviction, count)
//   cfg_     input      valid / ready    active slot count, 9 bits
//
// After reset a clearing pass marks every slot dead; no request is taken
// meanwhile, configuration writes are.
// A spawn reads at most n slot words, n being the active slot count, as the
// search reads one slot word a cycle from the single read port.
// A tick reads every slot, and ages and writes back each alive one.
// Requests are taken only between items; a result waiting on a stalled
// output register does not hold back the next request.
// ----------------------------------------------------------------------------
module lifetime_slot_pool_allocator_core
  import lspa_pkg::*;
#(
  parameter int unsigned SLOTS     = 256,
  parameter int unsigned LIFE_BITS = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_beat_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned NW = $clog2(SLOTS + 1);
  localparam int unsigned XW = NW + CFG_W;
  localparam int unsigned DW = LIFE_BITS + 1;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SRCH  = 5'b00100,
    ST_TICK  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CFG_W-1:0]     act_r;
  logic [IW-1:0]        last_r, last_nxt;
  logic [NW-1:0]        live_r, live_nxt;
  logic [NW-1:0]        iss_r, iss_nxt;
  logic [IW-1:0]        iss_addr_r, iss_addr_nxt;
  logic                 pv_r, pv_nxt;
  logic [IW-1:0]        paddr_r, paddr_nxt;
  logic [NW-1:0]        chk_r, chk_nxt;
  logic [NW-1:0]        n_r, n_nxt;
  logic [IW-1:0]        start_r, start_nxt;
  logic [LIFE_BITS-1:0] life_r, life_nxt;
  logic [ELAPSED_W-1:0] dt_r, dt_nxt;
  logic [IW-1:0]        slot_r, slot_nxt;
  logic                 evict_r, evict_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_beat_t            out_data_r, out_data_nxt;

  logic                 in_accept;
  logic                 out_free;
  logic [XW-1:0]        act_x;
  logic [NW-1:0]        n_eff;
  logic [NW-1:0]        chk_sum;
  logic [IW-1:0]        srch_start;

  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  logic [DW-1:0]        mem_wdata;
  logic                 mem_re;
  logic [IW-1:0]        mem_raddr;
  logic [DW-1:0]        mem_rdata;
  logic                 rd_alive;
  logic [LIFE_BITS-1:0] rd_life;
  logic                 age_keep;
  logic [LIFE_BITS-1:0] age_life;

  // Next slot in the active range, wrapping to slot zero.
  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] a,
                                             input logic [NW-1:0] lim);
    logic [NW:0] s;
    begin
      s = (NW + 1)'(a) + (NW + 1)'(1);
      if (s == (NW + 1)'(lim)) begin
        wrap_inc = '0;
      end else begin
        wrap_inc = IW'(s);
      end
    end
  endfunction

  // Slot table and the shared ageing unit.
  lspa_slot_mem #(
    .DEPTH  (SLOTS),
    .ADDR_W (IW),
    .DATA_W (DW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_alive = mem_rdata[DW-1];
  assign rd_life  = mem_rdata[LIFE_BITS-1:0];

  lspa_age_unit #(
    .LIFE_BITS (LIFE_BITS)
  ) u_age (
    .alive    (rd_alive),
    .life     (rd_life),
    .dt       (dt_r),
    .keep     (age_keep),
    .new_life (age_life)
  );

  // Handshakes.
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // Active slot count in force: zero acts as one, and it is capped at the pool size.
  always_comb begin
    act_x = XW'(act_r);
    if (act_x == '0) begin
      n_eff = NW'(1);
    end else if (act_x > XW'(SLOTS)) begin
      n_eff = NW'(SLOTS);
    end else begin
      n_eff = NW'(act_x);
    end
  end

  // A search starts at the last slot used unless it lies beyond the active range.
  assign srch_start = ((NW + 1)'(last_r) < (NW + 1)'(n_eff)) ? last_r : '0;
  assign chk_sum    = chk_r + NW'(pv_r);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    live_nxt      = live_r;
    iss_nxt       = iss_r;
    iss_addr_nxt  = iss_addr_r;
    pv_nxt        = pv_r;
    paddr_nxt     = paddr_r;
    chk_nxt       = chk_r;
    n_nxt         = n_r;
    start_nxt     = start_r;
    life_nxt      = life_r;
    dt_nxt        = dt_r;
    slot_nxt      = slot_r;
    evict_nxt     = evict_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = paddr_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = iss_addr_r;

    // The result register empties once its beat is taken.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = IW'(iss_r);
        mem_wdata = '0;
        iss_nxt   = iss_r + NW'(1);
        if (iss_r == NW'(SLOTS - 1)) begin
          iss_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          life_nxt     = LIFE_BITS'(in_data.lifetime);
          dt_nxt       = in_data.elapsed;
          n_nxt        = n_eff;
          start_nxt    = srch_start;
          iss_addr_nxt = srch_start;
          iss_nxt      = '0;
          chk_nxt      = '0;
          pv_nxt       = 1'b0;
          if (in_data.req_type == REQ_SPAWN) begin
            state_nxt = ST_SRCH;
          end else begin
            state_nxt = ST_TICK;
          end
        end
      end

      ST_SRCH: begin
        // Issue the next slot read while earlier data is checked.
        if (iss_r != n_r) begin
          mem_re       = 1'b1;
          mem_raddr    = iss_addr_r;
          paddr_nxt    = iss_addr_r;
          pv_nxt       = 1'b1;
          iss_nxt      = iss_r + NW'(1);
          iss_addr_nxt = wrap_inc(iss_addr_r, n_r);
        end else begin
          pv_nxt = 1'b0;
        end
        chk_nxt = chk_sum;
        if (pv_r && !rd_alive) begin
          // Dead slot found: claim it.
          mem_we    = 1'b1;
          mem_waddr = paddr_r;
          mem_wdata = {1'b1, life_r};
          slot_nxt  = paddr_r;
          evict_nxt = 1'b0;
          last_nxt  = paddr_r;
          live_nxt  = live_r + NW'(1);
          state_nxt = ST_DONE;
        end else if (chk_sum == n_r) begin
          // Every active slot is alive: overwrite the one after the start.
          mem_we    = 1'b1;
          mem_waddr = wrap_inc(start_r, n_r);
          mem_wdata = {1'b1, life_r};
          slot_nxt  = wrap_inc(start_r, n_r);
          evict_nxt = 1'b1;
          last_nxt  = wrap_inc(start_r, n_r);
          state_nxt = ST_DONE;
        end
      end

      ST_TICK: begin
        // Age the slot whose word has just come back.
        if (pv_r && rd_alive) begin
          mem_we    = 1'b1;
          mem_waddr = paddr_r;
          mem_wdata = age_keep ? {1'b1, age_life} : '0;
          if (!age_keep && (live_r != '0)) begin
            live_nxt = live_r - NW'(1);
          end
        end
        if (iss_r != NW'(SLOTS)) begin
          mem_re    = 1'b1;
          mem_raddr = IW'(iss_r);
          paddr_nxt = IW'(iss_r);
          pv_nxt    = 1'b1;
          iss_nxt   = iss_r + NW'(1);
        end else begin
          pv_nxt = 1'b0;
          if (!pv_r) begin
            slot_nxt  = '0;
            evict_nxt = 1'b0;
            state_nxt = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.slot_index  = SLOT_OUT_W'(slot_r);
          out_data_nxt.evicted     = evict_r;
          out_data_nxt.alive_count = COUNT_W'(live_r);
          state_nxt                = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      act_r       <= CFG_W'(256);
      last_r      <= '0;
      live_r      <= '0;
      iss_r       <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      live_r      <= live_nxt;
      iss_r       <= iss_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        act_r <= cfg_data;
      end
    end
  end

  // Working registers and the result beat.
  always_ff @(posedge clk) begin
    iss_addr_r <= iss_addr_nxt;
    paddr_r    <= paddr_nxt;
    chk_r      <= chk_nxt;
    n_r        <= n_nxt;
    start_r    <= start_nxt;
    life_r     <= life_nxt;
    dt_r       <= dt_nxt;
    slot_r     <= slot_nxt;
    evict_r    <= evict_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  // The alive total can never pass the pool size.
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= NW'(SLOTS))
    else $error("alive total exceeds pool size");

  // A result only appears as an item finishes.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the finishing state");

  // The search never reads more slots than are active.
  a_srch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRCH) |-> (iss_r <= n_r))
    else $error("search ran past the active slots");

  // The slot table is left alone between items.
  a_quiet_mem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_DONE) |-> !mem_we)
    else $error("slot table written between items");
`endif

endmodule

// ----- design/lspa_slot_mem.sv -----
// ----------------------------------------------------------------------------
// Slot table memory
// One write port and one read port with registered read data. Each word
// holds a slot's alive mark in the top bit and its remaining lifetime below.
// ----------------------------------------------------------------------------
module lspa_slot_mem #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 25
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data appears in the cycle after the address.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/lspa_age_unit.sv -----
// ----------------------------------------------------------------------------
// Slot ageing unit
// Shared subtract and compare: takes one slot word and the elapsed time and
// decides whether the slot stays alive, giving its reduced lifetime.
// ----------------------------------------------------------------------------
module lspa_age_unit
  import lspa_pkg::*;
#(
  parameter int unsigned LIFE_BITS = 24
) (
  input  logic                 alive,
  input  logic [LIFE_BITS-1:0] life,
  input  logic [ELAPSED_W-1:0] dt,
  output logic                 keep,
  output logic [LIFE_BITS-1:0] new_life
);

  localparam int unsigned BASE_W = (LIFE_BITS > ELAPSED_W) ? LIFE_BITS : ELAPSED_W;
  localparam int unsigned EXT_W  = BASE_W + 1;

  logic [EXT_W-1:0] diff;

  // The top bit of the difference is the borrow; a zero result also expires.
  always_comb begin
    diff     = EXT_W'(life) - EXT_W'(dt);
    keep     = alive && !diff[EXT_W-1] && (diff != '0);
    new_life = LIFE_BITS'(diff);
  end

endmodule
